// ----- design/rrc_pkg.sv -----
package rrc_pkg;

  localparam int MAX_REGISTERS = 8;
  localparam int IDX_W = $clog2(MAX_REGISTERS);
  localparam int JOB_DEPTH = 2;
  localparam int BANK_W = $clog2(JOB_DEPTH);
  localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);
  localparam int JOB_PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
  localparam int EXC_BIT = 7;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_ADDR = 3'd1;
  localparam logic [2:0] ST_EXC = 3'd2;
  localparam logic [2:0] ST_FUNC = 3'd3;
  localparam logic [2:0] ST_COUNT = 3'd4;
  localparam logic [2:0] ST_CRC = 3'd5;

  localparam logic [2:0] REG_SLAVE_ADDRESS = 3'd0;
  localparam logic [2:0] REG_EXPECTED_COUNT = 3'd4;

  // one finished frame handed from parser to emitter
  typedef struct packed {
    logic [2:0]        status;
    logic [7:0]        code;
    logic [3:0]        cnt;
    logic [BANK_W-1:0] bank;
  } rrc_job_t;

  // word buffer read port, emitter to parser
  typedef struct packed {
    logic [BANK_W-1:0] bank;
    logic [IDX_W-1:0]  idx;
  } rrc_rd_req_t;

endpackage

// ----- design/rrc_front.sv -----
module rrc_front
  import rrc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       rx_byte,
  input  logic             frame_start,
  input  logic [7:0]       slave_address,
  input  logic [3:0]       expected_register_count,
  input  logic             job_full,
  output logic             job_push,
  output rrc_job_t         job_data,
  input  rrc_rd_req_t      rd_req,
  output logic [15:0]      rd_data
);

  logic              frame_done_r, frame_done_nxt;
  logic [8:0]        pos_r, pos_nxt;
  logic [15:0]       crc_r, crc_nxt;
  logic [7:0]        addr_r, addr_nxt;
  logic [7:0]        func_r, func_nxt;
  logic [7:0]        dbc_r, dbc_nxt;
  logic [7:0]        crc_lo_r, crc_lo_nxt;
  logic [7:0]        hi_r, hi_nxt;
  logic [BANK_W-1:0] wr_bank_r, wr_bank_nxt;
  logic [15:0]       buf_r [JOB_DEPTH][MAX_REGISTERS];

  logic        take, active;
  logic [8:0]  pos_cur, flen, data_off;
  logic [15:0] crc_cur, crc_upd, recv_crc;
  logic        is_exc, in_hdr, in_body, at_crc_lo, at_end;
  logic [7:0]  word_idx;
  logic        buf_we, cnt_bad;
  logic [2:0]  status;

  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

  assign in_ready = !job_full;
  assign take = in_valid && in_ready;
  // drop bytes outside a frame
  assign active = take && (frame_start || !frame_done_r);

  assign pos_cur = frame_start ? 9'd0 : pos_r;
  assign crc_cur = frame_start ? CRC_INIT : crc_r;
  assign crc_upd = crc_step(crc_cur, rx_byte);

  assign is_exc = func_r[EXC_BIT];
  assign flen = is_exc ? 9'd5 : 9'd5 + {1'b0, dbc_r};
  assign in_hdr = pos_cur < 9'd3;
  assign in_body = !in_hdr && (pos_cur < flen - 9'd2);
  assign at_crc_lo = !in_hdr && (pos_cur == flen - 9'd2);
  assign at_end = !in_hdr && !in_body && !at_crc_lo;

  assign data_off = pos_cur - 9'd3;
  assign word_idx = data_off[8:1];
  assign buf_we = active && in_body && !is_exc && data_off[0]
                  && (word_idx < 8'(MAX_REGISTERS));

  assign recv_crc = {rx_byte, crc_lo_r};
  assign cnt_bad = (expected_register_count == 4'd0)
                   || ({4'd0, expected_register_count} > 8'(MAX_REGISTERS))
                   || (dbc_r != {3'd0, expected_register_count, 1'b0});

  always_comb begin
    if (addr_r != slave_address) begin
      status = ST_ADDR;
    end else if (is_exc) begin
      status = ST_EXC;
    end else if (func_r != FUNC_READ_HOLDING) begin
      status = ST_FUNC;
    end else if (cnt_bad) begin
      status = ST_COUNT;
    end else if (recv_crc != crc_r) begin
      status = ST_CRC;
    end else begin
      status = ST_OK;
    end
  end

  assign job_push = active && at_end;
  assign job_data.status = status;
  assign job_data.code = (status == ST_EXC) ? dbc_r : 8'd0;
  assign job_data.cnt = expected_register_count;
  assign job_data.bank = wr_bank_r;

  always_comb begin
    frame_done_nxt = frame_done_r;
    pos_nxt = pos_r;
    crc_nxt = crc_r;
    addr_nxt = addr_r;
    func_nxt = func_r;
    dbc_nxt = dbc_r;
    crc_lo_nxt = crc_lo_r;
    hi_nxt = hi_r;
    wr_bank_nxt = wr_bank_r;
    if (active) begin
      frame_done_nxt = at_end;
      pos_nxt = pos_cur + 9'd1;
      if (in_hdr || in_body) begin
        crc_nxt = crc_upd;
      end
      if (pos_cur == 9'd0) begin
        addr_nxt = rx_byte;
      end
      if (pos_cur == 9'd1) begin
        func_nxt = rx_byte;
      end
      if (pos_cur == 9'd2) begin
        dbc_nxt = rx_byte;
      end
      if (in_body && !is_exc && !data_off[0]) begin
        hi_nxt = rx_byte;
      end
      if (at_crc_lo) begin
        crc_lo_nxt = rx_byte;
      end
      // next frame fills the other bank
      if (at_end) begin
        wr_bank_nxt = wr_bank_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_done_r <= 1'b1;
      pos_r <= 9'd0;
      wr_bank_r <= '0;
    end else begin
      frame_done_r <= frame_done_nxt;
      pos_r <= pos_nxt;
      wr_bank_r <= wr_bank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
    addr_r <= addr_nxt;
    func_r <= func_nxt;
    dbc_r <= dbc_nxt;
    crc_lo_r <= crc_lo_nxt;
    hi_r <= hi_nxt;
    if (buf_we) begin
      buf_r[wr_bank_r][word_idx[IDX_W-1:0]] <= {hi_r, rx_byte};
    end
  end

  assign rd_data = buf_r[rd_req.bank][rd_req.idx];

endmodule

// ----- design/rrc_job_fifo.sv -----
module rrc_job_fifo
  import rrc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  rrc_job_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output rrc_job_t head_data
);

  rrc_job_t             mem_r [JOB_DEPTH];
  logic [JOB_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [JOB_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [JOB_CNT_W-1:0] count_r, count_nxt;

  function automatic logic [JOB_PTR_W-1:0] ptr_inc(input logic [JOB_PTR_W-1:0] p);
    return (p == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full = (count_r == JOB_CNT_W'(JOB_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt = count_r + JOB_CNT_W'(push) - JOB_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- design/rrc_emit.sv -----
module rrc_emit
  import rrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_valid,
  input  rrc_job_t    job,
  output logic        job_pop,
  output rrc_rd_req_t rd_req,
  input  logic [15:0] rd_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] register_value,
  output logic [2:0]  register_index,
  output logic [2:0]  status,
  output logic [7:0]  exception_code,
  output logic        last
);

  logic             valid_r, valid_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [15:0]      value_r;
  logic [2:0]       index_r;
  logic [2:0]       status_r;
  logic [7:0]       code_r;
  logic             last_r;

  logic load, is_err, word_last;

  assign load = job_valid && (!valid_r || out_ready);
  assign is_err = (job.status != ST_OK);
  assign word_last = ((4'(k_r) + 4'd1) == job.cnt);
  assign job_pop = load && (is_err || word_last);

  assign rd_req.bank = job.bank;
  assign rd_req.idx = k_r;

  always_comb begin
    valid_nxt = valid_r;
    k_nxt = k_r;
    if (load) begin
      valid_nxt = 1'b1;
      k_nxt = (is_err || word_last) ? '0 : k_r + 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      k_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      k_r <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value_r <= is_err ? 16'd0 : rd_data;
      index_r <= is_err ? 3'd0 : 3'(k_r);
      status_r <= job.status;
      code_r <= job.code;
      last_r <= is_err || word_last;
    end
  end

  assign out_valid = valid_r;
  assign register_value = value_r;
  assign register_index = index_r;
  assign status = status_r;
  assign exception_code = code_r;
  assign last = last_r;

endmodule

// ----- design/modbus_rtu_read_response_checker_core.sv -----
// Checks a Modbus RTU read-holding-registers reply, one received byte per input beat
// (in_tuser marks the first byte of a frame). The parser accepts a byte every cycle,
// keeps the running CRC16 and stores the data words in one of two word banks. When
// the last byte of a frame arrives it queues the frame's verdict; the emitter then
// sends one beat per cycle while out_tready is high: the N register words of a good
// frame (tlast on the final word) or a single status beat. Input stalls only while two
// finished frames are still queued for output, since each holds one bank.
module modbus_rtu_read_response_checker_core
  import rrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] register_value, [18:16] register_index,
                                  // [21:19] status, [29:22] exception_code
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [7:0] slave_address_r;
  logic [3:0] exp_count_r;
  logic       cfg_wr;

  logic        job_full, job_push, job_pop, job_valid;
  rrc_job_t    job_in, job_head;
  rrc_rd_req_t rd_req;
  logic [15:0] rd_data;

  logic [15:0] register_value;
  logic [2:0]  register_index;
  logic [2:0]  status;
  logic [7:0]  exception_code;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_address_r <= 8'd1;
      exp_count_r <= 4'd1;
    end else if (cfg_wr) begin
      // byte lanes inside a word are don't-care
      if ((cfg_paddr & 3'b100) == REG_SLAVE_ADDRESS) begin
        slave_address_r <= cfg_pwdata[7:0];
      end
      if ((cfg_paddr & 3'b100) == REG_EXPECTED_COUNT) begin
        exp_count_r <= cfg_pwdata[3:0];
      end
    end
  end

  assign cfg_prdata = ((cfg_paddr & 3'b100) == REG_EXPECTED_COUNT)
                      ? {28'd0, exp_count_r} : {24'd0, slave_address_r};

  rrc_front u_front (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_tvalid),
    .in_ready                (in_tready),
    .rx_byte                 (in_tdata),
    .frame_start             (in_tuser),
    .slave_address           (slave_address_r),
    .expected_register_count (exp_count_r),
    .job_full                (job_full),
    .job_push                (job_push),
    .job_data                (job_in),
    .rd_req                  (rd_req),
    .rd_data                 (rd_data)
  );

  rrc_job_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (job_push),
    .push_data  (job_in),
    .full       (job_full),
    .pop        (job_pop),
    .head_valid (job_valid),
    .head_data  (job_head)
  );

  rrc_emit u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .job_valid      (job_valid),
    .job            (job_head),
    .job_pop        (job_pop),
    .rd_req         (rd_req),
    .rd_data        (rd_data),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .register_value (register_value),
    .register_index (register_index),
    .status         (status),
    .exception_code (exception_code),
    .last           (out_tlast)
  );

  assign out_tdata = {2'b00, exception_code, status, register_index, register_value};

  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (status != ST_OK) |-> out_tlast)
    else $error("error status beat without tlast");

  a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (status != ST_OK) |-> (register_value == 16'd0)
      && (register_index == 3'd0))
    else $error("error status beat carries register data");

  a_code_only_exc: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (status != ST_EXC) |-> (exception_code == 8'd0))
    else $error("exception code on non-exception beat");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    job_full |-> !job_push)
    else $error("frame verdict pushed into full queue");

endmodule

// ----- verif/modbus_rtu_read_response_checker_core_test.sv -----
`timescale 1ns / 100ps

module modbus_rtu_read_response_checker_core_test;
  import rrc_pkg::*;

  typedef struct {
    logic [31:0] data;
    logic        last;
  } reply_beat_t;

  class reply_scoreboard;
    logic [7:0]  slave_addr;
    logic [3:0]  reg_count;
    logic [8:0]  pos;
    logic [15:0] crc;
    logic [7:0]  addr_b;
    logic [7:0]  func_b;
    logic [7:0]  count_b;
    logic [7:0]  crc_lo;
    logic [7:0]  high_b;
    logic [15:0] words [MAX_REGISTERS];
    bit          idle;
    reply_beat_t due_beats [$];
    int          errors;

    function new();
      slave_addr = 8'd1;
      reg_count = 4'd1;
      idle = 1'b1;
      errors = 0;
      clear_parser();
      foreach (words[i]) words[i] = 16'h0000;
    endfunction

    static function logic [15:0] crc16_next(logic [15:0] c, logic [7:0] b);
      c = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
    endfunction

    function void clear_parser();
      pos = '0;
      crc = CRC_INIT;
      addr_b = '0;
      func_b = '0;
      count_b = '0;
      crc_lo = '0;
      high_b = '0;
    endfunction

    function void set_config(logic [7:0] a, logic [3:0] c);
      slave_addr = a;
      reg_count = c;
    endfunction

    function int outstanding();
      return due_beats.size();
    endfunction

    function void add_beat(logic [15:0] value, logic [2:0] idx, logic [2:0] st,
                           logic [7:0] code, logic last);
      reply_beat_t b;
      b.data = {2'b00, code, st, idx, value};
      b.last = last;
      due_beats.insert(due_beats.size(), b);
    endfunction

    function void take_byte(logic [7:0] rx, logic start);
      int unsigned flen;
      int unsigned d;
      logic [15:0] got_crc;
      logic [2:0] st;
      if (start) begin
        clear_parser();
        idle = 1'b0;
      end else if (idle) begin
        return;
      end
      if (pos < 3) begin
        case (pos)
          9'd0: addr_b = rx;
          9'd1: func_b = rx;
          default: count_b = rx;
        endcase
        crc = crc16_next(crc, rx);
        pos = pos + 1'b1;
        return;
      end
      flen = func_b[EXC_BIT] ? 5 : 5 + count_b;
      if (pos < flen - 2) begin
        crc = crc16_next(crc, rx);
        if (!func_b[EXC_BIT]) begin
          d = pos - 3;
          if (d[0] == 1'b0) high_b = rx;
          else if ((d >> 1) < MAX_REGISTERS) words[d >> 1] = {high_b, rx};
        end
        pos = pos + 1'b1;
        return;
      end
      if (pos == flen - 2) begin
        crc_lo = rx;
        pos = pos + 1'b1;
        return;
      end
      // closing CRC byte: the verdict is due now
      idle = 1'b1;
      pos = pos + 1'b1;
      got_crc = {rx, crc_lo};
      if (addr_b != slave_addr) st = ST_ADDR;
      else if (func_b[EXC_BIT]) st = ST_EXC;
      else if (func_b != FUNC_READ_HOLDING) st = ST_FUNC;
      else if (reg_count < 1 || reg_count > MAX_REGISTERS || count_b != 8'(2 * reg_count))
        st = ST_COUNT;
      else if (got_crc != crc) st = ST_CRC;
      else st = ST_OK;
      if (st != ST_OK) begin
        add_beat(16'h0000, 3'd0, st, (st == ST_EXC) ? count_b : 8'h00, 1'b1);
      end else begin
        for (int k = 0; k < reg_count; k++)
          add_beat(words[k], 3'(k), ST_OK, 8'h00, (k + 1 == reg_count));
      end
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    task cmp_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
    endtask

    task check_beat(logic [31:0] data, logic last);
      reply_beat_t e;
      if (due_beats.size() == 0) begin
        report($sformatf("unexpected beat data %h last %b", data, last));
        return;
      end
      e = due_beats.pop_front();
      cmp_field("register_value", data[15:0], e.data[15:0]);
      cmp_field("register_index", 16'(data[18:16]), 16'(e.data[18:16]));
      cmp_field("status", 16'(data[21:19]), 16'(e.data[21:19]));
      cmp_field("exception_code", 16'(data[29:22]), 16'(e.data[29:22]));
      cmp_field("pad bits", 16'(data[31:30]), 16'(e.data[31:30]));
      cmp_field("tlast", 16'(last), 16'(e.last));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] rx_byte
  logic        in_tuser;   // [0] frame_start
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [15:0] register_value, [18:16] register_index,
                           // [21:19] status, [29:22] exception_code
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  reply_scoreboard sb;
  logic [8:0]      frame_q [$];   // {frame_start, rx_byte}
  int unsigned     bytes_taken;
  bit              calm;
  int unsigned     choke_req;
  int unsigned     choke_seen;
  int unsigned     hold_left;
  int unsigned     stalled;

  modbus_rtu_read_response_checker_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // receiver: random back-pressure, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (choke_req != choke_seen) begin
      choke_seen = choke_req;
      hold_left = 400;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 31);
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1)
      sb.check_beat(out_tdata, out_tlast);
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stalled = 0;
    end else begin
      stalled = stalled + 1;
      if (stalled >= 3000) begin
        $display("modbus_rtu_read_response_checker_core test failed");
        $finish;
      end
    end
  end

  task push_beat(input logic [7:0] b, input logic s);
    if (!calm && $urandom_range(99) < 30) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tuser <= s;
    do @(posedge clk); while (!in_tready);
    sb.take_byte(b, s);
    bytes_taken++;
  endtask

  task send_queue();
    foreach (frame_q[i]) push_beat(frame_q[i][7:0], frame_q[i][8]);
    frame_q.delete();
  endtask

  task cfg_write(input logic [2:0] addr, input logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function void stage(logic s, logic [7:0] b);
    frame_q.insert(frame_q.size(), {s, b});
  endfunction

  // append CRC of the frame opened by the latest start, with optional bit flips
  function void seal_frame(logic [15:0] flip);
    int first;
    logic [15:0] c;
    first = 0;
    foreach (frame_q[i]) if (frame_q[i][8]) first = i;
    c = CRC_INIT;
    for (int i = first; i < frame_q.size(); i++)
      c = reply_scoreboard::crc16_next(c, frame_q[i][7:0]);
    c = c ^ flip;
    stage(1'b0, c[7:0]);
    stage(1'b0, c[15:8]);
  endfunction

  function logic [7:0] data_byte();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  function void build_frame(logic [7:0] a, logic [7:0] f, logic [7:0] bc, logic [15:0] flip);
    stage(1'b1, a);
    stage(1'b0, f);
    stage(1'b0, bc);
    if (!f[EXC_BIT]) repeat (bc) stage(1'b0, data_byte());
    seal_frame(flip);
  endfunction

  function void random_frame(logic [7:0] a, logic [3:0] c);
    int kind;
    logic [7:0] addr;
    logic [7:0] f;
    logic [7:0] bc;
    logic [15:0] flip;
    int keep;
    kind = $urandom_range(99);
    addr = a;
    f = FUNC_READ_HOLDING;
    bc = 8'(2 * c);
    flip = 16'h0000;
    if (kind >= 94) begin
      // garbage stream with scattered starts
      repeat ($urandom_range(1, 12)) stage($urandom_range(3) == 0, 8'($urandom));
      return;
    end
    if (kind >= 88) begin
      // stray bytes outside any frame
      repeat ($urandom_range(1, 4)) stage(1'b0, 8'($urandom));
      return;
    end
    if (kind >= 45 && kind < 52) addr = 8'($urandom);
    else if (kind >= 52 && kind < 61) begin
      f = 8'($urandom) | 8'h80;
      bc = 8'($urandom);
      if ($urandom_range(1)) flip = 16'($urandom_range(1, 65535));
    end
    else if (kind >= 61 && kind < 67) f = 8'($urandom_range(0, 127));
    else if (kind >= 67 && kind < 74) bc = 8'($urandom_range(0, 20));
    else if (kind >= 74 && kind < 81) flip = 16'(1 << $urandom_range(15));
    build_frame(addr, f, bc, flip);
    if (kind >= 81) begin
      // cut the frame short; the next start drops it
      keep = $urandom_range(1, frame_q.size() - 1);
      while (frame_q.size() > keep) void'(frame_q.pop_back());
    end
  endfunction

  task run_phase(input logic [7:0] a, input logic [3:0] c, input int budget,
                 input bit oversized, input bit choke);
    int unsigned first;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_write(REG_SLAVE_ADDRESS, {24'h0, a});
    cfg_write(REG_EXPECTED_COUNT, {28'h0, c});
    sb.set_config(a, c);
    if (oversized) begin
      build_frame(a, FUNC_READ_HOLDING, 8'hFF, 16'h0000);
      send_queue();
    end
    if (choke) choke_req++;
    first = bytes_taken;
    while (bytes_taken - first < budget) begin
      random_frame(a, c);
      send_queue();
    end
    build_frame(a, FUNC_READ_HOLDING, 8'(2 * c), 16'h0000);
    send_queue();
    in_tvalid <= 1'b0;
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'h00;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    bytes_taken = 0;
    calm = 1'b0;
    choke_req = 0;
    choke_seen = 0;
    hold_left = 0;
    stalled = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // byte before any start: dropped
    stage(1'b0, 8'hA5);
    // opening of a frame cut off by the next start
    stage(1'b1, 8'h01);
    stage(1'b0, FUNC_READ_HOLDING);
    // good reply, one register of all ones
    stage(1'b1, 8'h01);
    stage(1'b0, FUNC_READ_HOLDING);
    stage(1'b0, 8'h02);
    stage(1'b0, 8'hFF);
    stage(1'b0, 8'hFF);
    seal_frame(16'h0000);
    // exception reply with a bad CRC is still an exception
    stage(1'b1, 8'h01);
    stage(1'b0, 8'h83);
    stage(1'b0, 8'h02);
    stage(1'b0, 8'h00);
    stage(1'b0, 8'h00);
    // wrong slave address
    stage(1'b1, 8'h00);
    stage(1'b0, FUNC_READ_HOLDING);
    stage(1'b0, 8'h02);
    stage(1'b0, 8'h00);
    stage(1'b0, 8'h00);
    seal_frame(16'h0000);
    // trailing byte after the frame end: dropped
    stage(1'b0, 8'h00);
    send_queue();
    in_tvalid <= 1'b0;

    run_phase(8'hFF, 4'd8, 10, 1'b1, 1'b0);
    run_phase(8'h5A, 4'd3, 35, 1'b0, 1'b1);
    calm = 1'b1;
    run_phase(8'h01, 4'd1, 20, 1'b0, 1'b0);
    calm = 1'b0;
    run_phase(8'h80, 4'd5, 10, 1'b0, 1'b0);
    run_phase(8'h33, 4'd0, 5, 1'b0, 1'b0);
    run_phase(8'hC3, 4'd15, 5, 1'b0, 1'b0);

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("modbus_rtu_read_response_checker_core test passed");
    end else begin
      $display("modbus_rtu_read_response_checker_core test failed");
    end
    $finish;
  end

endmodule
